### rtl/hex_grid_pixel_pick_core_macros.svh
// Assertion macros for the checker of the pixel pick core.
`ifndef HEX_GRID_PIXEL_PICK_CORE_MACROS_SVH
`define HEX_GRID_PIXEL_PICK_CORE_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define HGP_CHK_IMPL(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("hgp implication check failed");

// Next-cycle implication, checked during reset too.
`define HGP_CHK_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("hgp next-cycle check failed");

`endif

### rtl/hgp_pkg.sv
package hgp_pkg;

  typedef enum logic [2:0] {
    CFG_HALF_WIDTH     = 3'd0,
    CFG_QUARTER_HEIGHT = 3'd1,
    CFG_MARGIN_X       = 3'd2,
    CFG_MARGIN_Y       = 3'd3,
    CFG_FIELD_COLS     = 3'd4,
    CFG_FIELD_ROWS     = 3'd5,
    CFG_MAP_WIDTH      = 3'd6,
    CFG_MAP_HEIGHT     = 3'd7
  } cfg_reg_t;

  localparam logic [2:0] CODE_BLUE = 3'd0;
  localparam logic [2:0] CODE_RED  = 3'd1;
  localparam logic [2:0] CODE_NONE = 3'd4;

  // Item data that rides along the pipeline next to the dividers.
  typedef struct packed {
    logic        mode;
    logic [11:0] map_index;
    logic [2:0]  map_value;
    logic [11:0] px;
    logic        above;
    logic        below;
    logic        left;
    logic        wz;
    logic        right;
    logic [7:0]  row;
    logic [11:0] offy;
    logic [10:0] offx;
    logic [8:0]  col;
  } hgp_side_t;

endpackage

### rtl/hgp_div.sv
module hgp_div #(
  parameter int NW = 12,
  parameter int NQ = 12,
  parameter int DW = 12,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [NQ-1:0] quot,
  output logic [DW-1:0] rem,
  output logic [SW-1:0] side_out
);

  // Restoring division, one quotient bit per stage. Dividend bits above NQ
  // must already be below the divisor.
  logic          v  [NQ+1];
  logic [DW-1:0] r  [NQ+1];
  logic [NQ-1:0] q  [NQ+1];
  logic [NQ-1:0] lo [NQ+1];
  logic [SW-1:0] s  [NQ+1];
  logic [NW+DW-1:0] ext;

  assign ext = {{DW{1'b0}}, dividend};

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= in_valid;
    end
    r[0]  <= DW'(ext >> NQ);
    lo[0] <= dividend[NQ-1:0];
    q[0]  <= '0;
    s[0]  <= side_in;
  end

  for (genvar k = 1; k <= NQ; k++) begin : g_step
    logic [DW:0] t;
    logic        ge;
    assign t  = {r[k-1], lo[k-1][NQ-1]};
    assign ge = (t >= {1'b0, divisor});
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else begin
        v[k] <= v[k-1];
      end
      r[k]  <= ge ? DW'(t - {1'b0, divisor}) : t[DW-1:0];
      q[k]  <= NQ'({q[k-1], ge});
      lo[k] <= NQ'({lo[k-1], 1'b0});
      s[k]  <= s[k-1];
    end
  end

  assign out_valid = v[NQ];
  assign quot      = q[NQ];
  assign rem       = r[NQ];
  assign side_out  = s[NQ];

endmodule

### rtl/hgp_map.sv
module hgp_map #(
  parameter int AW = 12,
  parameter int MAP_ENTRIES = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  hgp_pkg::hgp_side_t side,
  input  logic [AW-1:0]     addr,
  input  logic [8:0]        cols,
  input  logic [8:0]        rows,
  output logic              done,
  output logic signed [9:0] hex_col,
  output logic signed [8:0] hex_row,
  output logic              inside_res,
  output logic              map_error
);
  import hgp_pkg::*;

  logic [2:0]  mem [MAP_ENTRIES];
  logic        wr_en;
  logic        m_valid;
  hgp_side_t   m_side;
  logic [2:0]  code;

  logic signed [9:0] col_n;
  logic signed [8:0] row_n;
  logic              err_n;
  logic              inside_n;
  logic signed [9:0] dcol;
  logic signed [8:0] drow;

  assign wr_en = in_valid && side.mode && (32'(side.map_index) < MAP_ENTRIES);

  // Loads write in the same stage where picks read, so order holds.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(side.map_index)] <= side.map_value;
    end else begin
      code <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= in_valid;
    end
    m_side <= side;
  end

  always_comb begin
    dcol  = '0;
    drow  = '0;
    err_n = 1'b0;
    unique case (code)
      CODE_NONE: ;
      CODE_RED: begin
        drow = -9'sd1;
        if (!m_side.row[0]) dcol = -10'sd1;
      end
      CODE_BLUE: begin
        drow = -9'sd1;
        if (m_side.row[0]) dcol = 10'sd1;
      end
      default: err_n = 1'b1;
    endcase

    priority if (m_side.mode) begin
      col_n = '0; row_n = '0; err_n = 1'b0; inside_n = 1'b0;
    end else if (m_side.above || m_side.below) begin
      col_n = '0; row_n = -9'sd1; err_n = 1'b0; inside_n = 1'b0;
    end else if (m_side.left || m_side.wz || m_side.right) begin
      col_n = -10'sd1; row_n = '0; err_n = 1'b0; inside_n = 1'b0;
    end else begin
      col_n = $signed({1'b0, m_side.col}) + dcol;
      row_n = $signed({1'b0, m_side.row}) + drow;
      inside_n = !col_n[9] && (col_n[8:0] < cols) && !row_n[8] && ({1'b0, row_n[7:0]} < rows);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m_valid;
    end
    hex_col    <= col_n;
    hex_row    <= row_n;
    inside_res <= inside_n;
    map_error  <= err_n;
  end

endmodule

### rtl/hex_grid_pixel_pick_core.sv
// Pixel pick for a pointy-top hex grid with odd rows shifted half a hex.
// One word is taken every clock: start is accepted whenever busy is low,
// and busy is high only during reset and for the cycle after it. Each word,
// pick or load, yields exactly one result, shown for one cycle with done
// high; the receiver cannot stall, so there is no backpressure. Each word
// passes through the chain of bit-serial divider pipelines (row and column
// at 13 stages each, both map scalings in parallel at 8), one quotient bit
// per stage, plus the product register, the address register, two stages of
// reciprocal multiply that wrap the table address, the table read and the
// output register. Loads write the mouse map in program order with picks.
// Configure only while idle.
module hex_grid_pixel_pick_core #(
  parameter int MAP_ENTRIES = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              mode,
  input  logic [11:0]       pixel_x,
  input  logic [11:0]       pixel_y,
  input  logic [11:0]       map_index,
  input  logic [2:0]        map_value,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [11:0]       cfg_data,
  output logic              done,
  output logic signed [9:0] hex_col,
  output logic signed [8:0] hex_row,
  output logic              inside_res,
  output logic              map_error
);
  import hgp_pkg::*;

  localparam int AW = $clog2(MAP_ENTRIES);
  // Address before the wrap, and the reciprocal that divides it by the depth.
  localparam int IW = 14;
  localparam int SH = IW + AW;
  localparam int RW = IW + 2;
  localparam int PW = IW + RW;
  localparam longint RECIP_L =
    ((longint'(1) << SH) + longint'(MAP_ENTRIES) - 1) / longint'(MAP_ENTRIES);
  localparam logic [RW-1:0] RECIP = RW'(RECIP_L);

  // Configuration registers.
  logic [9:0]  half_width;
  logic [9:0]  quarter_height;
  logic [11:0] margin_x;
  logic [11:0] margin_y;
  logic [8:0]  field_cols;
  logic [8:0]  field_rows;
  logic [6:0]  map_width;
  logic [6:0]  map_height;

  logic [11:0] pitch;
  logic [10:0] wide;
  logic [8:0]  cols;
  logic [8:0]  rows;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_width     <= 10'd17;
      quarter_height <= 10'd10;
      margin_x       <= '0;
      margin_y       <= '0;
      field_cols     <= 9'd8;
      field_rows     <= 9'd8;
      map_width      <= 7'd64;
      map_height     <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_HALF_WIDTH:     half_width     <= cfg_data[9:0];
        CFG_QUARTER_HEIGHT: quarter_height <= cfg_data[9:0];
        CFG_MARGIN_X:       margin_x       <= cfg_data;
        CFG_MARGIN_Y:       margin_y       <= cfg_data;
        CFG_FIELD_COLS:     field_cols     <= cfg_data[8:0];
        CFG_FIELD_ROWS:     field_rows     <= cfg_data[8:0];
        CFG_MAP_WIDTH:      map_width      <= cfg_data[6:0];
        CFG_MAP_HEIGHT:     map_height     <= cfg_data[6:0];
      endcase
    end
  end

  // Hold off the first word for a cycle out of reset.
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // Row pitch is three quarter heights, hex width two half widths; fields
  // wider than 256 clamp to 256.
  assign pitch = 12'({2'b0, quarter_height}) + {1'b0, quarter_height, 1'b0};
  assign wide  = {half_width, 1'b0};
  assign cols  = field_cols[8] ? 9'd256 : field_cols;
  assign rows  = field_rows[8] ? 9'd256 : field_rows;

  // Entry: drop the top margin and start the row divide.
  logic [12:0] y_diff;
  hgp_side_t   s0;

  assign y_diff = {1'b0, pixel_y} - {1'b0, margin_y};

  always_comb begin
    s0           = '0;
    s0.mode      = mode;
    s0.map_index = map_index;
    s0.map_value = map_value;
    s0.px        = pixel_x;
    s0.above     = y_diff[12] || (pitch == '0);
  end

  logic        v1;
  logic [11:0] row_q;
  logic [11:0] offy;
  hgp_side_t   s1;

  hgp_div #(.NW(12), .NQ(12), .DW(12), .SW($bits(hgp_side_t))) u_div_row (
    .clk(clk), .rst(rst), .in_valid(start && !busy),
    .dividend(y_diff[11:0]), .divisor(pitch), .side_in(s0),
    .out_valid(v1), .quot(row_q), .rem(offy), .side_out(s1)
  );

  // Row known: test the bottom edge, shift odd rows, drop the left margin.
  logic [13:0] x_diff;
  hgp_side_t   s1n;

  assign x_diff = {2'b0, s1.px} - {2'b0, margin_x}
                - (row_q[0] ? {4'b0, half_width} : 14'd0);

  always_comb begin
    s1n       = s1;
    s1n.below = (row_q >= {3'b0, rows});
    s1n.left  = x_diff[13];
    s1n.wz    = (half_width == '0);
    s1n.row   = row_q[7:0];
    s1n.offy  = offy;
  end

  logic        v2;
  logic [11:0] col_q;
  logic [10:0] offx;
  hgp_side_t   s2;

  hgp_div #(.NW(12), .NQ(12), .DW(11), .SW($bits(hgp_side_t))) u_div_col (
    .clk(clk), .rst(rst), .in_valid(v1),
    .dividend(x_diff[11:0]), .divisor(wide), .side_in(s1n),
    .out_valid(v2), .quot(col_q), .rem(offx), .side_out(s2)
  );

  // Column known: test the right edge and scale both offsets into the map.
  logic        p_valid;
  hgp_side_t   p_side;
  hgp_side_t   s2n;
  logic [17:0] prod_x;
  logic [18:0] prod_y;

  always_comb begin
    s2n       = s2;
    s2n.right = (col_q >= {3'b0, cols});
    s2n.col   = col_q[8:0];
    s2n.offx  = offx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= v2;
    end
    p_side <= s2n;
    prod_x <= 18'(offx) * 18'(map_width);
    prod_y <= 19'(s2.offy) * 19'(map_height);
  end

  logic        v3;
  logic [6:0]  effx;
  logic [6:0]  effy;
  logic [10:0] rem_x;
  logic [11:0] rem_y;
  hgp_side_t   s3;

  // Quotients stay below the map size, so seven bits cover them.
  hgp_div #(.NW(18), .NQ(7), .DW(11), .SW($bits(hgp_side_t))) u_div_mx (
    .clk(clk), .rst(rst), .in_valid(p_valid),
    .dividend(prod_x), .divisor(wide), .side_in(p_side),
    .out_valid(v3), .quot(effx), .rem(rem_x), .side_out(s3)
  );

  hgp_div #(.NW(19), .NQ(7), .DW(12), .SW(1)) u_div_my (
    .clk(clk), .rst(rst), .in_valid(p_valid),
    .dividend(prod_y), .divisor(pitch), .side_in(1'b0),
    .out_valid(), .quot(effy), .rem(rem_y), .side_out()
  );

  // Table address before the wrap.
  logic        i_valid;
  hgp_side_t   i_side;
  logic [13:0] idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      i_valid <= 1'b0;
    end else begin
      i_valid <= v3;
    end
    i_side <= s3;
    idx    <= 14'(effy) * 14'(map_width) + 14'(effx);
  end

  // Wrap the address modulo the table depth: multiply by the reciprocal to
  // get the quotient, then subtract quotient times depth.
  logic          w_valid;
  hgp_side_t     w_side;
  logic [IW-1:0] w_idx;
  logic [IW-1:0] w_quot;
  logic [PW-1:0] recip_prod;
  logic [31:0]   quot_mul;
  logic          a_valid;
  hgp_side_t     a_side;
  logic [IW-1:0] addr_mod;

  assign recip_prod = PW'(idx) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid <= 1'b0;
    end else begin
      w_valid <= i_valid;
    end
    w_side <= i_side;
    w_idx  <= idx;
    w_quot <= IW'(recip_prod >> SH);
  end

  assign quot_mul = 32'(w_quot) * 32'(MAP_ENTRIES);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= w_valid;
    end
    a_side   <= w_side;
    addr_mod <= w_idx - IW'(quot_mul);
  end

  hgp_map #(.AW(AW), .MAP_ENTRIES(MAP_ENTRIES)) u_map (
    .clk(clk), .rst(rst), .in_valid(a_valid), .side(a_side),
    .addr(AW'(addr_mod)), .cols(cols), .rows(rows),
    .done(done), .hex_col(hex_col), .hex_row(hex_row),
    .inside_res(inside_res), .map_error(map_error)
  );

  logic unused_rem;
  assign unused_rem = ^{rem_x, rem_y};

endmodule

### rtl/hgp_chk.sv
`include "hex_grid_pixel_pick_core_macros.svh"

module hgp_chk (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic signed [9:0] hex_col,
  input logic signed [8:0] hex_row,
  input logic              inside_res,
  input logic              map_error
);

  `HGP_CHK_NEXT(a_no_done_after_rst, rst, !done)
  `HGP_CHK_NEXT(a_busy_only_after_rst, !rst, !busy)
  `HGP_CHK_IMPL(a_inside_nonneg, done && inside_res, !hex_col[9] && !hex_row[8])
  `HGP_CHK_IMPL(a_error_in_field, done && map_error, !hex_col[9] && !hex_row[8])

  logic unused_start;
  assign unused_start = start;

endmodule

bind hex_grid_pixel_pick_core hgp_chk u_chk (.*);
